FILE: rtl/core/sliding_window_median_macros.svh
// Assertion macros for the sliding window median block.
// Used by modules that declare clk and rst_n; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_MACROS_SVH

// Check a consequence in the same cycle as its condition
`define SWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/swm_pkg.sv
// Shared types and constants for the sliding window median block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int MAX_WINDOW = 64;
    localparam int CHANNELS   = 4;
    localparam int SAMPLE_W   = 32;
    localparam int CH_W       = 2;
    localparam int LEN_W      = 7;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = IDX_W + 1;
    localparam int CH_SEL_W   = $clog2(CHANNELS);
    localparam int HIST_AW    = CH_SEL_W + IDX_W;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic [CH_W-1:0] channel_index;
        sample_t         sample;
    } swm_in_t;

    typedef struct packed {
        logic [CH_W-1:0] channel_out;
        sample_t         median;
    } swm_out_t;

    // Broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic                upd;
        logic                exch;
        logic [CH_SEL_W-1:0] ch;
        logic [CNT_W-1:0]    limit;
        sample_t             s;
        sample_t             old;
    } swm_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_PICK   = 4'b1000
    } swm_state_t;

endpackage

FILE: rtl/core/swm_cell.sv
// One sorted-window cell: holds one sorted slot for every channel.
// Depends on swm_pkg; instantiated by swm_chain.
`timescale 1ns / 1ps

module swm_cell (
    input  logic                       clk,
    input  logic [swm_pkg::IDX_W-1:0]  idx,
    input  swm_pkg::swm_ctrl_t         ctrl,
    input  swm_pkg::sample_t           prev_val,
    input  logic                       prev_before,
    input  logic                       prev_le,
    input  swm_pkg::sample_t           next_val,
    output swm_pkg::sample_t           cur_val,
    output logic                       cur_before,
    output logic                       cur_le
);
    import swm_pkg::*;

    sample_t val_reg [CHANNELS];
    sample_t val_next;
    sample_t b_cur;
    sample_t b_prev;

    // Select the slot of the active channel
    assign cur_val = val_reg[ctrl.ch];

    // Entries below the removed one stay; in insert mode nothing is removed
    assign cur_before = ctrl.exch ? (cur_val < ctrl.old) : 1'b1;

    // Window contents after removal, at this slot and the one below
    assign b_cur  = cur_before  ? cur_val  : next_val;
    assign b_prev = prev_before ? prev_val : cur_val;

    // Slot keeps its entry when it lies below the limit and that entry sorts at or below the new sample
    assign cur_le = ({1'b0, idx} < ctrl.limit) && (b_cur <= ctrl.s);

    // Keep, take the new sample, or shift up from below
    always_comb
    begin
        priority if (cur_le)
            val_next = b_cur;
        else if (prev_le)
            val_next = ctrl.s;
        else
            val_next = b_prev;
    end

    // Write back the active channel's slot
    always_ff @(posedge clk)
    begin
        if (ctrl.upd)
        begin
            val_reg[ctrl.ch] <= val_next;
        end
    end

endmodule

FILE: rtl/core/swm_chain.sv
// Row of sorted-window cells with neighbor links and median selection.
// Depends on swm_pkg and swm_cell.
`timescale 1ns / 1ps

module swm_chain (
    input  logic                       clk,
    input  swm_pkg::swm_ctrl_t         ctrl,
    input  logic [swm_pkg::IDX_W-1:0]  pick_idx,
    output swm_pkg::sample_t           median
);
    import swm_pkg::*;

    sample_t                cell_val  [MAX_WINDOW];
    sample_t                prev_val  [MAX_WINDOW];
    sample_t                next_val  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  cell_before;
    logic [MAX_WINDOW-1:0]  cell_le;
    logic [MAX_WINDOW-1:0]  prev_before;
    logic [MAX_WINDOW-1:0]  prev_le;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++)
        begin : g_cell
            // Bottom of the row sees an empty neighbor that sorts below all
            if (gi == 0)
            begin : g_head
                assign prev_val[gi]    = '0;
                assign prev_before[gi] = 1'b1;
                assign prev_le[gi]     = 1'b1;
            end
            else
            begin : g_link_down
                assign prev_val[gi]    = cell_val[gi-1];
                assign prev_before[gi] = cell_before[gi-1];
                assign prev_le[gi]     = cell_le[gi-1];
            end

            if (gi == MAX_WINDOW - 1)
            begin : g_tail
                assign next_val[gi] = cell_val[gi];
            end
            else
            begin : g_link_up
                assign next_val[gi] = cell_val[gi+1];
            end

            swm_cell u_cell (
                .clk         (clk),
                .idx         (IDX_W'(gi)),
                .ctrl        (ctrl),
                .prev_val    (prev_val[gi]),
                .prev_before (prev_before[gi]),
                .prev_le     (prev_le[gi]),
                .next_val    (next_val[gi]),
                .cur_val     (cell_val[gi]),
                .cur_before  (cell_before[gi]),
                .cur_le      (cell_le[gi])
            );
        end
    endgenerate

    // Pick the middle slot of the active channel
    assign median = cell_val[pick_idx];

endmodule

FILE: rtl/core/sliding_window_median.sv
// Top level of the sliding window median block: control, history ring, output register.
// Depends on swm_pkg, swm_chain and sliding_window_median_macros.svh.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------
//   in        | in_valid/in_stall  | in_item  (channel, sample)
//   out       | out_valid/out_stall| out_item (channel, median)
//   cfg       | cfg_wr_en          | cfg_wr_data (window length)
//
// An item passes in order through capture, history ring read, cell row update and median pick.
// The history ring is a single-port-read memory with registered read data, and the
// cell row updates one channel per cycle, so one item is in flight at a time.
// A result waits in the output register; a stalled output holds the pick step.
// Reset clears counters and control; sorted cells and the history ring need no clearing.
`timescale 1ns / 1ps

`include "sliding_window_median_macros.svh"

module sliding_window_median (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  swm_pkg::swm_in_t       in_item,
    output logic                   out_valid,
    input  logic                   out_stall,
    output swm_pkg::swm_out_t      out_item,
    input  logic                   cfg_wr_en,
    input  logic [swm_pkg::LEN_W-1:0] cfg_wr_data
);
    import swm_pkg::*;

    swm_state_t             state_reg;
    swm_state_t             state_next;
    logic [LEN_W-1:0]       len_reg;
    logic [CNT_W-1:0]       fill_reg [CHANNELS];
    logic [IDX_W-1:0]       pos_reg  [CHANNELS];
    logic                   out_valid_reg;
    swm_out_t               out_item_reg;

    logic [CH_SEL_W-1:0]    ch_reg;
    logic [CH_SEL_W-1:0]    ch_next;
    sample_t                s_reg;
    logic                   exch_reg;
    logic [CNT_W-1:0]       limit_reg;
    logic [CNT_W-1:0]       limit_next;
    logic [IDX_W-1:0]       pick_reg;
    logic [IDX_W-1:0]       pick_next;
    sample_t                hist_rd_reg;
    sample_t                hist_mem [CHANNELS * MAX_WINDOW];

    logic                   in_xfer;
    logic                   out_load;
    logic [CNT_W-1:0]       n_cur;
    logic [CNT_W-1:0]       n_new;
    logic [IDX_W-1:0]       pos_cur;
    logic [IDX_W-1:0]       slot;
    logic [CNT_W-1:0]       len_eff;
    logic                   exch_cur;
    logic [HIST_AW-1:0]     rd_addr;
    logic [HIST_AW-1:0]     wr_addr;
    swm_ctrl_t              ctrl;
    sample_t                median;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_PICK) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Fold an out-of-range channel onto the last one
    always_comb
    begin
        if (int'(in_item.channel_index) >= CHANNELS)
            ch_next = CH_SEL_W'(CHANNELS - 1);
        else
            ch_next = CH_SEL_W'(in_item.channel_index);
    end

    // Clamp the configured length to one .. MAX_WINDOW
    always_comb
    begin
        priority if (len_reg == '0)
            len_eff = CNT_W'(1);
        else if (CNT_W'(len_reg) > CNT_W'(MAX_WINDOW))
            len_eff = CNT_W'(MAX_WINDOW);
        else
            len_eff = CNT_W'(len_reg);
    end

    // Decide insert or exchange for the captured channel
    assign n_cur      = fill_reg[ch_reg];
    assign pos_cur    = pos_reg[ch_reg];
    assign exch_cur   = (n_cur >= len_eff);
    assign slot       = pos_cur + n_cur[IDX_W-1:0];
    assign rd_addr    = {ch_reg, pos_cur};
    assign wr_addr    = {ch_reg, slot};
    assign n_new      = exch_cur ? n_cur : n_cur + CNT_W'(1);
    assign limit_next = exch_cur ? n_cur - CNT_W'(1) : n_cur;
    assign pick_next  = IDX_W'(n_new >> 1);

    // Sequence one item through read, update and pick
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_READ;
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_PICK;
            ST_PICK:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_RESET;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fill_reg[c] <= '0;
                pos_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                len_reg <= cfg_wr_data;
            if (state_reg == ST_READ)
            begin
                if (exch_cur)
                    pos_reg[ch_reg] <= pos_cur + IDX_W'(1);
                else
                    fill_reg[ch_reg] <= n_new;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the item, hold per-item payload and load the output register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ch_reg <= ch_next;
            s_reg  <= in_item.sample;
        end
        if (state_reg == ST_READ)
        begin
            exch_reg  <= exch_cur;
            limit_reg <= limit_next;
            pick_reg  <= pick_next;
        end
        if (out_load)
        begin
            out_item_reg.channel_out <= CH_W'(ch_reg);
            out_item_reg.median      <= median;
        end
    end

    // History ring: read the oldest sample, write the new one
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            hist_rd_reg       <= hist_mem[rd_addr];
            hist_mem[wr_addr] <= s_reg;
        end
    end

    // Drive the cell row
    assign ctrl.upd   = (state_reg == ST_UPDATE);
    assign ctrl.exch  = exch_reg;
    assign ctrl.ch    = ch_reg;
    assign ctrl.limit = limit_reg;
    assign ctrl.s     = s_reg;
    assign ctrl.old   = hist_rd_reg;

    swm_chain u_chain (
        .clk      (clk),
        .ctrl     (ctrl),
        .pick_idx (pick_reg),
        .median   (median)
    );

    `SWM_ASSERT_NEXT(a_accept_read, in_xfer, state_reg == ST_READ, "transfer did not start a read")
    `SWM_ASSERT_SAME(a_fill_bound, state_reg == ST_READ, n_cur <= CNT_W'(MAX_WINDOW), "fill count beyond window")
    `SWM_ASSERT_SAME(a_exch_nonempty, (state_reg == ST_READ) && exch_cur, n_cur != '0, "exchange on empty window")
    `SWM_ASSERT_SAME(a_limit_bound, state_reg == ST_UPDATE, limit_reg < CNT_W'(MAX_WINDOW), "insert limit overflows row")
    `SWM_ASSERT_NEXT(a_update_pick, state_reg == ST_UPDATE, state_reg == ST_PICK, "update not followed by pick")

endmodule
